/* design/hpc_pkg.sv */
// shared types, constants and tables of the helix plane crossing block
package hpc_pkg;

  localparam int ITER_LIMIT = 20;
  localparam int IT_W = $clog2(ITER_LIMIT + 1);
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [63:0] ONE_Q30       = 64'sd1073741824;
  localparam logic signed [63:0] WIDE_LIM      = 64'sd1152921504606846976;
  localparam logic signed [63:0] INV_TWO_PI    = 64'sd683565276;
  localparam logic signed [63:0] ANG_MAX       = 64'sd901943132;
  localparam logic signed [63:0] SHRINK_Q16    = 64'sd58982;
  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;

  typedef struct packed {
    logic        [31:0] curvature;
    logic signed [31:0] cos_dip;
    logic signed [31:0] sin_dip;
    logic signed [31:0] phase;
    logic signed [31:0] cos_phase;
    logic signed [31:0] sin_phase;
    logic               helicity_negative;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } hpc_in_t;

  typedef enum logic [1:0] {
    OUT_FOUND = 2'd0,
    OUT_NOSOL = 2'd1,
    OUT_SAT   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [31:0] path_length;
    outcome_t           outcome;
  } hpc_out_t;

  typedef enum logic [2:0] {
    REG_PX   = 3'd0,
    REG_PY   = 3'd1,
    REG_PZ   = 3'd2,
    REG_NX   = 3'd3,
    REG_NY   = 3'd4,
    REG_NZ   = 3'd5,
    REG_PREC = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_LD,
    ST_DIV,
    ST_CORD,
    ST_CORD_END,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    M_PX, M_PY, M_PZ, M_D1, M_D2, M_D3, M_D4, M_D5,
    M_A1, M_A2, M_A3, M_TQ, M_TB, M_PB, M_U,
    M_BAM, M_F1, M_F2, M_F3, M_P1, M_P2, M_P3, M_P4, M_G, M_SH
  } mop_t;

  typedef enum logic [1:0] {
    DV_LINE,
    DV_DELTA,
    DV_STEP
  } div_kind_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    case (i)
      5'd0:  atan_bam = 32'h20000000;
      5'd1:  atan_bam = 32'h12E4051E;
      5'd2:  atan_bam = 32'h09FB385B;
      5'd3:  atan_bam = 32'h051111D4;
      5'd4:  atan_bam = 32'h028B0D43;
      5'd5:  atan_bam = 32'h0145D7E1;
      5'd6:  atan_bam = 32'h00A2F61E;
      5'd7:  atan_bam = 32'h00517C55;
      5'd8:  atan_bam = 32'h0028BE53;
      5'd9:  atan_bam = 32'h00145F2F;
      5'd10: atan_bam = 32'h000A2F98;
      5'd11: atan_bam = 32'h000517CC;
      5'd12: atan_bam = 32'h00028BE6;
      5'd13: atan_bam = 32'h000145F3;
      5'd14: atan_bam = 32'h0000A2F9;
      5'd15: atan_bam = 32'h0000517C;
      5'd16: atan_bam = 32'h000028BE;
      5'd17: atan_bam = 32'h0000145F;
      5'd18: atan_bam = 32'h00000A2F;
      5'd19: atan_bam = 32'h00000517;
      5'd20: atan_bam = 32'h0000028B;
      5'd21: atan_bam = 32'h00000145;
      5'd22: atan_bam = 32'h000000A2;
      5'd23: atan_bam = 32'h00000051;
      5'd24: atan_bam = 32'h00000028;
      5'd25: atan_bam = 32'h00000014;
      5'd26: atan_bam = 32'h0000000A;
      5'd27: atan_bam = 32'h00000005;
      5'd28: atan_bam = 32'h00000002;
      5'd29: atan_bam = 32'h00000001;
      default: atan_bam = 32'h00000000;
    endcase
  endfunction

  function automatic logic signed [63:0] sext32(input logic [31:0] v);
    sext32 = {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] clamp_unit(input logic [31:0] v);
    logic signed [63:0] w;
    w = {{32{v[31]}}, v};
    if (w > ONE_Q30) clamp_unit = ONE_Q30;
    else if (w < -ONE_Q30) clamp_unit = -ONE_Q30;
    else clamp_unit = w;
  endfunction

  function automatic logic signed [63:0] clamp_wide(input logic signed [63:0] v);
    if (v > WIDE_LIM) clamp_wide = WIDE_LIM;
    else if (v < -WIDE_LIM) clamp_wide = -WIDE_LIM;
    else clamp_wide = v;
  endfunction

endpackage

/* design/helix_plane_crossing.sv */
// helix plane crossing: sequencer around a shared multiplier, divider and cordic
// One track beat in, one result beat out. The block takes one item at a time and
// in_ready is low while it works. Every product goes through one 32x32 multiplier
// as four partial products plus a finishing step, divisions run one quotient bit
// a cycle and sin/cos come from a 30-step cordic. A curved track takes at most 20
// Newton steps. The next track is taken while a finished result still waits on
// the output register.
module helix_plane_crossing import hpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  hpc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hpc_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration
  logic [31:0] ppx_r, ppy_r, ppz_r, nrx_r, nry_r, nrz_r;
  logic [15:0] prec_r;

  state_t  state_r, state_nxt;
  hpc_in_t item_r, item_nxt;
  mop_t    op_r, op_nxt;
  logic [2:0]   mcnt_r, mcnt_nxt;
  logic [127:0] prod_r, prod_nxt;

  logic signed [63:0] acc_r, acc_nxt, num_r, num_nxt, d1_r, d1_nxt, tmp_r, tmp_nxt;
  logic signed [63:0] a0_r, a0_nxt, tq_r, tq_nxt, t_r, t_nxt, tb_r, tb_nxt;
  logic signed [63:0] u_r, u_nxt, f_r, f_nxt, fp_r, fp_nxt;
  logic [31:0]        pb_r, pb_nxt;
  logic signed [31:0] deltas_r, deltas_nxt, s_r, s_nxt;
  logic signed [33:0] shift_r, shift_nxt;
  logic               found_r, found_nxt, sat_r, sat_nxt;
  logic [IT_W-1:0]    it_r, it_nxt;

  div_kind_t   dkind_r, dkind_nxt;
  logic [95:0] rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [30:0] dq_r, dq_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic        dsat_r, dsat_nxt, dzero_r, dzero_nxt, dneg_r, dneg_nxt;

  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [4:0]         ci_r, ci_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic signed [31:0] ca_r, ca_nxt, sa_r, sa_nxt;

  logic     out_valid_r, out_valid_nxt;
  hpc_out_t out_data_r, out_data_nxt;

  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                input logic [4:0] n);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : v;
    m = m >> n;
    shr_tz = v[33] ? 34'(-$signed(m)) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp_c(input logic signed [33:0] v);
    if (v > 34'sd1073741824) clamp_c = 32'sd1073741824;
    else if (v < -34'sd1073741824) clamp_c = -32'sd1073741824;
    else clamp_c = v[31:0];
  endfunction

  // clamped and widened operands
  logic signed [63:0] nx, ny, nz, cd, sd, cp, sp, cv, ph, ddx, ddy, ddz;
  assign nx  = clamp_unit(nrx_r);
  assign ny  = clamp_unit(nry_r);
  assign nz  = clamp_unit(nrz_r);
  assign cd  = clamp_unit(item_r.cos_dip);
  assign sd  = clamp_unit(item_r.sin_dip);
  assign cp  = clamp_unit(item_r.cos_phase);
  assign sp  = clamp_unit(item_r.sin_phase);
  assign cv  = {32'b0, item_r.curvature};
  assign ph  = sext32(item_r.phase);
  assign ddx = sext32(ppx_r) - sext32(item_r.origin_x);
  assign ddy = sext32(ppy_r) - sext32(item_r.origin_y);
  assign ddz = sext32(ppz_r) - sext32(item_r.origin_z);

  logic [63:0] f_abs;
  logic signed [63:0] fp_abs;
  assign f_abs  = f_r[63] ? 64'(-f_r) : f_r;
  assign fp_abs = fp_r[63] ? -fp_r : fp_r;

  // operand select for the shared multiplier
  logic signed [63:0] opa, opb;
  logic [4:0] sh;
  always_comb begin
    opa = nx;
    opb = cp;
    sh  = 5'd30;
    case (op_r)
      M_PX:  begin opa = ddx;      opb = nx; end
      M_PY:  begin opa = ddy;      opb = ny; end
      M_PZ:  begin opa = ddz;      opb = nz; end
      M_D1:  begin opa = nz;       opb = sd; end
      M_D2:  begin opa = cd;       opb = cp; end
      M_D3:  begin opa = ny;       opb = tmp_r; end
      M_D4:  begin opa = cd;       opb = sp; end
      M_D5:  begin opa = nx;       opb = tmp_r; end
      M_A1:  begin opa = cv;       opb = -num_r; sh = 5'd18; end
      M_A2:  begin opa = nx;       opb = cp; end
      M_A3:  begin opa = ny;       opb = sp; end
      M_TQ:  begin opa = cv;       opb = cd; end
      M_TB:  begin opa = t_r;      opb = INV_TWO_PI; sh = 5'd24; end
      M_PB:  begin opa = ph;       opb = INV_TWO_PI; sh = 5'd29; end
      M_U:   begin opa = d1_r;     opb = cv; end
      M_BAM: begin opa = tb_r;     opb = sext32(s_r); end
      M_F1:  begin opa = nx;       opb = sext32(ca_r); end
      M_F2:  begin opa = ny;       opb = sext32(sa_r); end
      M_F3:  begin opa = u_r;      opb = sext32(s_r); sh = 5'd18; end
      M_P1:  begin opa = ny;       opb = sext32(ca_r); end
      M_P2:  begin opa = tmp_r;    opb = t_r; end
      M_P3:  begin opa = nx;       opb = sext32(sa_r); end
      M_P4:  begin opa = tmp_r;    opb = t_r; end
      M_G:   begin opa = fp_abs;   opb = sext32(deltas_r); sh = 5'd18; end
      M_SH:  begin opa = sext32(deltas_r); opb = SHRINK_Q16; sh = 5'd16; end
      default: begin opa = nx;     opb = cp; end
    endcase
  end

  // shared multiplier: one 32x32 partial product a cycle
  logic [63:0]  mag_a, mag_b, pp, low64;
  logic [31:0]  pa, pb_half, raw32;
  logic [127:0] pp_sh, prod_shr;
  logic         mneg, msat;
  logic [63:0]  r_mag;
  logic signed [63:0] mres;
  assign mag_a   = opa[63] ? 64'(-opa) : opa;
  assign mag_b   = opb[63] ? 64'(-opb) : opb;
  assign mneg    = opa[63] ^ opb[63];
  assign pa      = mcnt_r[1] ? mag_a[63:32] : mag_a[31:0];
  assign pb_half = mcnt_r[0] ? mag_b[63:32] : mag_b[31:0];
  assign pp      = pa * pb_half;
  always_comb begin
    case (mcnt_r[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end
  assign prod_shr = prod_r >> sh;
  assign msat     = (|prod_shr[127:61]) || (prod_shr[60] && (|prod_shr[59:0]));
  assign r_mag    = msat ? 64'(WIDE_LIM) : {3'b0, prod_shr[60:0]};
  assign mres     = mneg ? -$signed(r_mag) : $signed(r_mag);
  // wrapped product for the angle advance
  assign low64    = mneg ? 64'(-prod_r[63:0]) : prod_r[63:0];
  assign raw32    = low64[55:24];

  logic signed [63:0] den_val;
  logic le, pos;
  assign den_val = acc_r - mres;
  assign le      = $unsigned(mres) <= f_abs;
  assign pos     = (fp_r[63] == f_r[63]);

  // angle to cordic start
  logic [31:0] bam, bam_q;
  logic [1:0]  qd;
  logic [31:0] bres;
  assign bam   = pb_r + raw32;
  assign bam_q = bam + 32'h20000000;
  assign qd    = bam_q[31:30];
  assign bres  = bam - {qd, 30'b0};

  // divider load and bit step
  logic signed [63:0] dn, dd;
  logic [4:0]  frac;
  logic [63:0] dn_abs, dd_abs;
  logic [95:0] n_sh, d_lim;
  always_comb begin
    case (dkind_r)
      DV_LINE:  begin dn = num_r;   dd = acc_r; frac = 5'd30; end
      // step limit divides by the magnitude of the turn rate
      DV_DELTA: begin dn = ANG_MAX; dd = tq_r[63] ? -tq_r : tq_r; frac = 5'd16; end
      DV_STEP:  begin dn = f_r;     dd = fp_r;  frac = 5'd18; end
      default:  begin dn = f_r;     dd = fp_r;  frac = 5'd18; end
    endcase
  end
  assign dn_abs = dn[63] ? 64'(-dn) : dn;
  assign dd_abs = dd[63] ? 64'(-dd) : dd;
  assign n_sh   = {32'b0, dn_abs} << frac;
  assign d_lim  = {32'b0, dd_abs} << 31;

  logic        dge, dlast;
  logic [30:0] dqf;
  logic signed [31:0] dres;
  assign dge   = rem_r >= dsh_r;
  assign dqf   = {dq_r[29:0], dge};
  assign dlast = dsat_r || (dcnt_r == 5'd30);
  always_comb begin
    if (dzero_r) dres = 32'sh7FFFFFFF;
    else if (dsat_r) dres = dneg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    else dres = dneg_r ? 32'(-$signed({1'b0, dqf})) : $signed({1'b0, dqf});
  end

  // cordic step
  logic signed [33:0] xs, ys, atn;
  assign xs  = shr_tz(cx_r, ci_r);
  assign ys  = shr_tz(cy_r, ci_r);
  assign atn = $signed({2'b0, atan_bam(ci_r)});

  logic signed [31:0] xc, yc;
  assign xc = clamp_c(cx_r);
  assign yc = clamp_c(cy_r);

  // newton update
  logic signed [33:0] ns_full, ns_diff;
  logic signed [31:0] ns;
  logic               ns_sat, found_new, it_last;
  logic [33:0]        ns_abs;
  always_comb begin
    ns_full = {{2{s_r[31]}}, s_r} - shift_r;
    ns_sat  = 1'b0;
    if (ns_full > 34'sd2147483647) begin
      ns = 32'sh7FFFFFFF;
      ns_sat = 1'b1;
    end else if (ns_full < -34'sd2147483648) begin
      ns = 32'sh80000000;
      ns_sat = 1'b1;
    end else begin
      ns = ns_full[31:0];
    end
  end
  assign ns_diff   = {{2{s_r[31]}}, s_r} - {{2{ns[31]}}, ns};
  assign ns_abs    = ns_diff[33] ? 34'(-ns_diff) : ns_diff;
  assign found_new = ns_abs < {18'b0, prec_r};
  assign it_last   = it_r == IT_W'(ITER_LIMIT - 1);

  logic out_load;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mcnt_r == 3'd4) begin
          case (op_r)
            M_D5:    state_nxt = (den_val == 64'sd0) ? ST_DONE : ST_DIV_LD;
            M_U:     state_nxt = (tq_r == 64'sd0) ? ST_MUL : ST_DIV_LD;
            M_BAM:   state_nxt = ST_CORD;
            M_G:     state_nxt = le ? (pos ? ST_UPD : ST_MUL) : ST_DIV_LD;
            M_SH:    state_nxt = ST_UPD;
            default: state_nxt = ST_MUL;
          endcase
        end
      end
      ST_DIV_LD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dlast) begin
          case (dkind_r)
            DV_LINE:  state_nxt = ST_DONE;
            DV_DELTA: state_nxt = ST_MUL;
            default:  state_nxt = ST_UPD;
          endcase
        end
      end
      ST_CORD: begin
        if (ci_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_CORD_END;
      end
      ST_CORD_END: state_nxt = ST_MUL;
      ST_UPD: state_nxt = (found_new || it_last) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_data_r;
    cfg_ready = 1'b1;
  end

  // datapath
  always_comb begin
    item_nxt = item_r;   op_nxt = op_r;       mcnt_nxt = mcnt_r;   prod_nxt = prod_r;
    acc_nxt = acc_r;     num_nxt = num_r;     d1_nxt = d1_r;       tmp_nxt = tmp_r;
    a0_nxt = a0_r;       tq_nxt = tq_r;       t_nxt = t_r;         tb_nxt = tb_r;
    u_nxt = u_r;         f_nxt = f_r;         fp_nxt = fp_r;       pb_nxt = pb_r;
    deltas_nxt = deltas_r; s_nxt = s_r;       shift_nxt = shift_r;
    found_nxt = found_r; sat_nxt = sat_r;     it_nxt = it_r;
    dkind_nxt = dkind_r; rem_nxt = rem_r;     dsh_nxt = dsh_r;     dq_nxt = dq_r;
    dcnt_nxt = dcnt_r;   dsat_nxt = dsat_r;   dzero_nxt = dzero_r; dneg_nxt = dneg_r;
    cx_nxt = cx_r;       cy_nxt = cy_r;       cz_nxt = cz_r;       ci_nxt = ci_r;
    quad_nxt = quad_r;   ca_nxt = ca_r;       sa_nxt = sa_r;
    out_data_nxt = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          op_nxt    = M_PX;
          mcnt_nxt  = 3'd0;
          prod_nxt  = '0;
          s_nxt     = '0;
          found_nxt = 1'b0;
          sat_nxt   = 1'b0;
          it_nxt    = '0;
        end
      end
      ST_MUL: begin
        if (mcnt_r != 3'd4) begin
          prod_nxt = prod_r + pp_sh;
          mcnt_nxt = mcnt_r + 3'd1;
        end else begin
          prod_nxt = '0;
          mcnt_nxt = 3'd0;
          case (op_r)
            M_PX: begin acc_nxt = mres; op_nxt = M_PY; end
            M_PY: begin acc_nxt = acc_r + mres; op_nxt = M_PZ; end
            M_PZ: begin num_nxt = acc_r + mres; op_nxt = M_D1; end
            M_D1: begin
              d1_nxt  = mres;
              acc_nxt = mres;
              op_nxt  = (item_r.curvature == 32'd0) ? M_D2 : M_A1;
            end
            M_D2: begin tmp_nxt = mres; op_nxt = M_D3; end
            M_D3: begin acc_nxt = acc_r + mres; op_nxt = M_D4; end
            M_D4: begin tmp_nxt = mres; op_nxt = M_D5; end
            M_D5: begin acc_nxt = den_val; dkind_nxt = DV_LINE; end
            M_A1: begin acc_nxt = mres; op_nxt = M_A2; end
            M_A2: begin acc_nxt = acc_r - mres; op_nxt = M_A3; end
            M_A3: begin a0_nxt = acc_r - mres; op_nxt = M_TQ; end
            M_TQ: begin
              tq_nxt = mres;
              t_nxt  = item_r.helicity_negative ? -mres : mres;
              op_nxt = M_TB;
            end
            M_TB: begin tb_nxt = mres; op_nxt = M_PB; end
            M_PB: begin pb_nxt = mres[31:0]; op_nxt = M_U; end
            M_U: begin
              u_nxt = mres;
              if (tq_r == 64'sd0) begin
                deltas_nxt = 32'sh7FFFFFFF;
                op_nxt     = M_BAM;
              end else begin
                dkind_nxt = DV_DELTA;
              end
            end
            M_BAM: begin
              cx_nxt   = CORDIC_GAIN;
              cy_nxt   = '0;
              cz_nxt   = {{2{bres[31]}}, bres};
              quad_nxt = qd;
              ci_nxt   = '0;
            end
            M_F1: begin acc_nxt = a0_r + mres; op_nxt = M_F2; end
            M_F2: begin acc_nxt = acc_r + mres; op_nxt = M_F3; end
            M_F3: begin f_nxt = clamp_wide(acc_r + mres); op_nxt = M_P1; end
            M_P1: begin tmp_nxt = mres; op_nxt = M_P2; end
            M_P2: begin acc_nxt = mres; op_nxt = M_P3; end
            M_P3: begin tmp_nxt = mres; op_nxt = M_P4; end
            M_P4: begin fp_nxt = clamp_wide(acc_r - mres + u_r); op_nxt = M_G; end
            M_G: begin
              if (le) begin
                if (pos) shift_nxt = {2'b0, deltas_r};
                else op_nxt = M_SH;
              end else begin
                dkind_nxt = DV_STEP;
              end
            end
            M_SH: shift_nxt = 34'(-mres);
            default: op_nxt = op_r;
          endcase
        end
      end
      ST_DIV_LD: begin
        rem_nxt   = n_sh;
        dsh_nxt   = {32'b0, dd_abs} << 30;
        dq_nxt    = '0;
        dcnt_nxt  = '0;
        dzero_nxt = (dd_abs == 64'd0);
        dsat_nxt  = (dd_abs == 64'd0) || (n_sh >= d_lim);
        dneg_nxt  = dn[63] ^ dd[63];
      end
      ST_DIV: begin
        rem_nxt  = dge ? rem_r - dsh_r : rem_r;
        dq_nxt   = dqf;
        dsh_nxt  = dsh_r >> 1;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dlast) begin
          case (dkind_r)
            DV_LINE: begin
              s_nxt     = dres;
              sat_nxt   = dsat_r;
              found_nxt = 1'b1;
            end
            DV_DELTA: begin
              deltas_nxt = dres;
              op_nxt     = M_BAM;
            end
            default: shift_nxt = {{2{dres[31]}}, dres};
          endcase
        end
      end
      ST_CORD: begin
        if (!cz_r[33]) begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - atn;
        end else begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + atn;
        end
        ci_nxt = ci_r + 5'd1;
      end
      ST_CORD_END: begin
        case (quad_r)
          2'd0:    begin ca_nxt = xc;  sa_nxt = yc;  end
          2'd1:    begin ca_nxt = -yc; sa_nxt = xc;  end
          2'd2:    begin ca_nxt = -xc; sa_nxt = -yc; end
          default: begin ca_nxt = yc;  sa_nxt = -xc; end
        endcase
        op_nxt = M_F1;
      end
      ST_UPD: begin
        s_nxt     = ns;
        sat_nxt   = ns_sat;
        found_nxt = found_new;
        it_nxt    = it_r + IT_W'(1);
        op_nxt    = M_BAM;
      end
      ST_DONE: begin
        if (out_load) begin
          if (found_r) begin
            out_data_nxt.path_length = s_r;
            out_data_nxt.outcome     = sat_r ? OUT_SAT : OUT_FOUND;
          end else begin
            out_data_nxt.path_length = '0;
            out_data_nxt.outcome     = OUT_NOSOL;
          end
        end
      end
      default: op_nxt = op_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ppx_r       <= '0;
      ppy_r       <= '0;
      ppz_r       <= '0;
      nrx_r       <= '0;
      nry_r       <= '0;
      nrz_r       <= 32'h40000000;
      prec_r      <= 16'd66;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PX:   ppx_r  <= cfg_data;
          REG_PY:   ppy_r  <= cfg_data;
          REG_PZ:   ppz_r  <= cfg_data;
          REG_NX:   nrx_r  <= cfg_data;
          REG_NY:   nry_r  <= cfg_data;
          REG_NZ:   nrz_r  <= cfg_data;
          REG_PREC: prec_r <= cfg_data[15:0];
          default:  prec_r <= prec_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;   op_r <= op_nxt;       mcnt_r <= mcnt_nxt;   prod_r <= prod_nxt;
    acc_r <= acc_nxt;     num_r <= num_nxt;     d1_r <= d1_nxt;       tmp_r <= tmp_nxt;
    a0_r <= a0_nxt;       tq_r <= tq_nxt;       t_r <= t_nxt;         tb_r <= tb_nxt;
    u_r <= u_nxt;         f_r <= f_nxt;         fp_r <= fp_nxt;       pb_r <= pb_nxt;
    deltas_r <= deltas_nxt; s_r <= s_nxt;       shift_r <= shift_nxt;
    found_r <= found_nxt; sat_r <= sat_nxt;     it_r <= it_nxt;
    dkind_r <= dkind_nxt; rem_r <= rem_nxt;     dsh_r <= dsh_nxt;     dq_r <= dq_nxt;
    dcnt_r <= dcnt_nxt;   dsat_r <= dsat_nxt;   dzero_r <= dzero_nxt; dneg_r <= dneg_nxt;
    cx_r <= cx_nxt;       cy_r <= cy_nxt;       cz_r <= cz_nxt;       ci_r <= ci_nxt;
    quad_r <= quad_nxt;   ca_r <= ca_nxt;       sa_r <= sa_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* design/hpc_checker.sv */
// port-level checks of the helix plane crossing block and their bind
module hpc_checker import hpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input hpc_out_t    out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.outcome == OUT_FOUND || out_data.outcome == OUT_NOSOL ||
                   out_data.outcome == OUT_SAT))
    else $error("undefined outcome code");

  a_nosol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OUT_NOSOL |-> out_data.path_length == 32'sd0)
    else $error("no-solution result with nonzero length");

  // one track in flight: ready drops after a track beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second track taken while busy");

endmodule

bind helix_plane_crossing hpc_checker u_hpc_checker (.*);

/* tb/sv/helix_plane_crossing_tb.sv */
// testbench for the helix plane crossing block: directed and random tracks against a bit-exact predictor
module helix_plane_crossing_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;

  localparam longint UNIT_Q30  = 64'sd1073741824;
  localparam longint SAT_LIM   = 64'sd1152921504606846976;
  localparam longint RECIP_2PI = 64'sd683565276;
  localparam longint TURN_MAX  = 64'sd901943132;
  localparam longint DAMP_Q16  = 64'sd58982;
  localparam longint ROT_GAIN  = 64'sd652032874;
  localparam int     STEP_CAP  = 20;

  class crossing_board;
    logic [31:0] plane_regs [7];
    hpc_out_t    expected_crossings [$];
    int          errors;
    longint      arc_tab [30];

    function new();
      plane_regs = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h40000000, 32'd66};
      arc_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                  64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
                  64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
                  64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
                  64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
                  64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      plane_regs[idx] = (idx == REG_PREC) ? {16'd0, val[15:0]} : val;
    endfunction

    function longint abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint unit_clip(logic [31:0] v);
      longint w;
      w = $signed(v);
      return w > UNIT_Q30 ? UNIT_Q30 : (w < -UNIT_Q30 ? -UNIT_Q30 : w);
    endfunction

    function longint wide_clip(longint v);
      return v > SAT_LIM ? SAT_LIM : (v < -SAT_LIM ? -SAT_LIM : v);
    endfunction

    function longint shift_tz(longint v, int sh);
      longint m;
      m = abs64(v) >>> sh;
      return v < 0 ? -m : m;
    endfunction

    // truncating product, scaled down and saturated at 2^60
    function longint prod_shift(longint a, longint b, int sh);
      logic [127:0] p;
      logic [63:0]  ua, ub;
      longint       r;
      ua = abs64(a);
      ub = abs64(b);
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> sh;
      if (p > SAT_LIM) p = SAT_LIM;
      r = p[63:0];
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function longint quot_fix(longint num, longint den, int frac, output bit sat);
      logic [63:0] un, ud, q, r;
      bit          neg;
      neg = (num < 0) != (den < 0);
      un = abs64(num);
      ud = abs64(den);
      sat = 0;
      if (ud == 0) begin
        sat = 1;
        return 64'sh7FFFFFFF;
      end
      q = un / ud;
      r = un % ud;
      if (q > 64'h7FFFFFFF) sat = 1;
      for (int i = 0; i < frac && !sat; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q[0] = 1'b1;
        end
        if (q > 64'h7FFFFFFF) sat = 1;
      end
      if (sat) return neg ? -64'sh80000000 : 64'sh7FFFFFFF;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void sincos(logic [31:0] ang, output longint co, output longint si);
      logic [31:0] q, res;
      longint      z, x, y, nx;
      q = (ang + 32'h20000000) >> 30;
      res = ang - (q << 30);
      z = $signed(res);
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          nx = x - shift_tz(y, i);
          y = y + shift_tz(x, i);
          z = z - arc_tab[i];
        end else begin
          nx = x + shift_tz(y, i);
          y = y - shift_tz(x, i);
          z = z + arc_tab[i];
        end
        x = nx;
      end
      x = x > UNIT_Q30 ? UNIT_Q30 : (x < -UNIT_Q30 ? -UNIT_Q30 : x);
      y = y > UNIT_Q30 ? UNIT_Q30 : (y < -UNIT_Q30 ? -UNIT_Q30 : y);
      case (q[1:0])
        2'd0: begin co = x;  si = y;  end
        2'd1: begin co = -y; si = x;  end
        2'd2: begin co = -x; si = -y; end
        default: begin co = y; si = -x; end
      endcase
    endfunction

    function hpc_out_t crossing_of(hpc_in_t trk);
      longint px, py, pz, nx, ny, nz, prec, c, cd, sd, ph, cp, sp, ox, oy, oz;
      longint s, num, den, dot, a0, tq, t, tb, u, deltas, ca, sa, f, fp, shift, ns;
      logic [63:0] pb, pr;
      bit found, sat, dsat;
      hpc_out_t r;
      px = $signed(plane_regs[REG_PX]);
      py = $signed(plane_regs[REG_PY]);
      pz = $signed(plane_regs[REG_PZ]);
      nx = unit_clip(plane_regs[REG_NX]);
      ny = unit_clip(plane_regs[REG_NY]);
      nz = unit_clip(plane_regs[REG_NZ]);
      prec = plane_regs[REG_PREC][15:0];
      c = {32'd0, trk.curvature};
      cd = unit_clip(trk.cos_dip);
      sd = unit_clip(trk.sin_dip);
      ph = trk.phase;
      cp = unit_clip(trk.cos_phase);
      sp = unit_clip(trk.sin_phase);
      ox = trk.origin_x;
      oy = trk.origin_y;
      oz = trk.origin_z;
      s = 0;
      found = 0;
      sat = 0;
      if (c == 0) begin
        num = prod_shift(px - ox, nx, 30) + prod_shift(py - oy, ny, 30)
            + prod_shift(pz - oz, nz, 30);
        den = prod_shift(nz, sd, 30) + prod_shift(ny, prod_shift(cd, cp, 30), 30)
            - prod_shift(nx, prod_shift(cd, sp, 30), 30);
        if (den != 0) begin
          s = quot_fix(num, den, 30, sat);
          found = 1;
        end
      end else begin
        dot = prod_shift(ox - px, nx, 30) + prod_shift(oy - py, ny, 30)
            + prod_shift(oz - pz, nz, 30);
        a0 = prod_shift(c, dot, 18) - prod_shift(nx, cp, 30) - prod_shift(ny, sp, 30);
        tq = prod_shift(c, cd, 30);
        t = trk.helicity_negative ? -tq : tq;
        tb = prod_shift(t, RECIP_2PI, 24);
        pb = prod_shift(ph, RECIP_2PI, 29);
        u = prod_shift(prod_shift(nz, sd, 30), c, 30);
        deltas = 64'sh7FFFFFFF;
        if (tq != 0) deltas = quot_fix(TURN_MAX, abs64(tq), 16, dsat);
        for (int i = 0; i < STEP_CAP && !found; i++) begin
          pr = tb * s;
          sincos(pb[31:0] + pr[55:24], ca, sa);
          f = wide_clip(a0 + prod_shift(nx, ca, 30) + prod_shift(ny, sa, 30)
                        + prod_shift(u, s, 18));
          fp = wide_clip(prod_shift(prod_shift(ny, ca, 30), t, 30)
                         - prod_shift(prod_shift(nx, sa, 30), t, 30) + u);
          // newton step too long or flat derivative: take the clamped step
          if (prod_shift(abs64(fp), deltas, 18) <= abs64(f))
            shift = ((fp < 0) == (f < 0)) ? deltas : -prod_shift(deltas, DAMP_Q16, 16);
          else
            shift = quot_fix(f, fp, 18, dsat);
          ns = s - shift;
          sat = 0;
          if (ns > 64'sh7FFFFFFF) begin
            ns = 64'sh7FFFFFFF;
            sat = 1;
          end
          if (ns < -64'sh80000000) begin
            ns = -64'sh80000000;
            sat = 1;
          end
          if (abs64(s - ns) < prec) found = 1;
          s = ns;
        end
      end
      if (!found) begin
        r.path_length = '0;
        r.outcome = OUT_NOSOL;
      end else begin
        r.path_length = s[31:0];
        r.outcome = sat ? OUT_SAT : OUT_FOUND;
      end
      return r;
    endfunction

    function void note_track(hpc_in_t trk);
      expected_crossings.push_back(crossing_of(trk));
    endfunction

    function void check_crossing(hpc_out_t got);
      hpc_out_t want;
      if (expected_crossings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat path=%0d outcome=%0d",
                 $realtime, got.path_length, got.outcome);
        return;
      end
      want = expected_crossings.pop_front();
      if (got.path_length !== want.path_length) begin
        errors++;
        $display("%0t: path_length expected %0d actual %0d",
                 $realtime, want.path_length, got.path_length);
      end
      if (got.outcome !== want.outcome) begin
        errors++;
        $display("%0t: outcome expected %0d actual %0d", $realtime, want.outcome, got.outcome);
      end
    endfunction

    function int pending();
      return expected_crossings.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  hpc_in_t     in_data;
  hpc_out_t    out_data;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  crossing_board board = new();
  int hold_cycles = 0;
  int burst_left = 0;

  helix_plane_crossing dut (.*);

  always #10 clk = ~clk;

  initial begin
    #200ms;
    $display("helix_plane_crossing_tb: done, errors");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) board.check_crossing(out_data);

  // receiver: long hold on request, otherwise a ready pattern re-picked at random from four modes
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = (cyc % 3 == 0);
          2: out_ready = $urandom_range(0, 1);
          default: out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] to_q30(real r);
    return $rtoi(r * 1073741824.0);
  endfunction

  function automatic logic [31:0] mm_q16(int lim_mm);
    return $signed($urandom_range(0, 2 * lim_mm * 65536)) - lim_mm * 65536;
  endfunction

  function automatic hpc_in_t track_of(logic [31:0] c, logic [31:0] cd, logic [31:0] sd,
                                       logic [31:0] ph, logic [31:0] cp, logic [31:0] sp,
                                       logic h, logic [31:0] ox, logic [31:0] oy,
                                       logic [31:0] oz);
    hpc_in_t t;
    t = '{c, cd, sd, ph, cp, sp, h, ox, oy, oz};
    return t;
  endfunction

  function automatic hpc_in_t random_track();
    real lam, phi;
    logic [31:0] c;
    if ($urandom_range(0, 3) == 0)
      return track_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 1), $urandom, $urandom, $urandom);
    lam = ($signed($urandom_range(0, 2800)) - 1400) / 1000.0;
    phi = ($signed($urandom_range(0, 6282)) - 3141) / 1000.0;
    c = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 20000000);
    return track_of(c, to_q30($cos(lam)), to_q30($sin(lam)), $rtoi(phi * 536870912.0),
                    to_q30($cos(phi)), to_q30($sin(phi)), $urandom_range(0, 1),
                    mm_q16(1500), mm_q16(1500), mm_q16(1500));
  endfunction

  // offer one track beat; sender bursts and gaps live here
  task automatic push_track(hpc_in_t trk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = trk;
    do @(posedge clk); while (!in_ready);
    board.note_track(trk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                            logic [31:0] prec);
    write_reg(REG_PX, px);
    write_reg(REG_PY, py);
    write_reg(REG_PZ, pz);
    write_reg(REG_NX, nx);
    write_reg(REG_NY, ny);
    write_reg(REG_NZ, nz);
    write_reg(REG_PREC, prec);
  endtask

  initial begin
    hpc_in_t directed [$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PX;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset plane: z = 0, normal along z
    directed = '{
      track_of(0, 0, to_q30(1.0), 0, to_q30(1.0), 0, 0, 0, 0, -32'sd6553600),
      track_of(0, to_q30(1.0), 0, 0, to_q30(1.0), 0, 0, 0, 0, -32'sd6553600),
      track_of(0, 0, 1, 0, to_q30(1.0), 0, 0, 0, 0, 32'h80000000),
      track_of(4294967, to_q30(0.7071), to_q30(0.7071), 0, to_q30(1.0), 0, 0,
               0, 0, -32'sd3276800),
      track_of(4294967, to_q30(0.7071), to_q30(0.7071), 0, to_q30(1.0), 0, 1,
               0, 0, -32'sd3276800),
      track_of(4294967, 0, to_q30(1.0), 0, to_q30(1.0), 0, 0, 0, 0, -32'sd3276800),
      track_of(32'hFFFFFFFF, to_q30(0.5), to_q30(0.866), 0, to_q30(1.0), 0, 1,
               0, 0, -32'sd655360),
      track_of(4294967, 32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0,
               0, 0, 32'sd655360),
      track_of(1000000, to_q30(0.6), to_q30(0.8), 32'sd1686629713, to_q30(-1.0), 0, 0,
               0, 0, -32'sd655360),
      track_of(1000000, to_q30(0.6), to_q30(0.8), -32'sd1686629713, to_q30(-1.0), 0, 1,
               32'h7FFFFFFF, 32'h80000000, 32'h80000000),
      track_of(4294967, to_q30(1.0), 0, 0, to_q30(1.0), 0, 0, 0, 0, -32'sd655360),
      track_of(0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
      track_of('1, '1, '1, '1, '1, '1, 1, '1, '1, '1),
      '0
    };
    foreach (directed[i]) push_track(directed[i]);

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      drain();
      case (phase_no)
        0: load_plane(0, 0, 32'sd32768000, 0, 0, to_q30(1.0), 66);
        1: load_plane(mm_q16(500), mm_q16(500), mm_q16(500), to_q30(1.0), 0, 0, 65535);
        2: load_plane(32'h7FFFFFFF, 32'h80000000, 0, to_q30(-1.0), 0, to_q30(-1.0), 1);
        3: load_plane(mm_q16(300), mm_q16(300), 0, 32'sd644245094, 32'sd858993459, 0, 300);
        4: load_plane(0, 0, mm_q16(800), 32'h7FFFFFFF, 32'h80000000, 32'h40000001, 500);
        default: load_plane(0, 0, 32'sd6553600, 0, to_q30(-0.6), to_q30(0.8), 0);
      endcase
      for (int n = 0; n < (phase_no == 5 ? 20 : 75); n++) begin
        // hold the receiver off so finished results back up into the input
        if (phase_no == 1 && n == 10) hold_cycles = 6000;
        push_track(random_track());
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (board.errors == 0)
      $display("helix_plane_crossing_tb: done, clean");
    else
      $display("helix_plane_crossing_tb: done, errors");
    $finish;
  end

endmodule
